// File: rtl/ifpdl_pkg.sv
// ----------------------------------------------------------------------------
// ifpdl_pkg
// Shared types and constants of the inverter frequency panel loader.
// ----------------------------------------------------------------------------
package ifpdl_pkg;

  localparam int unsigned FreqW  = 10;
  localparam int unsigned StepW  = 7;
  localparam int unsigned TuneW  = 20;
  localparam int unsigned WordW  = 16;
  localparam int unsigned CsW    = 3;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CfgFreqMin = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgFreqMax = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgTuning  = 2'd2;

  localparam logic [FreqW-1:0] FreqMinReset = 10'd10;
  localparam logic [FreqW-1:0] FreqMaxReset = 10'd1000;
  localparam logic [FreqW-1:0] TuningReset  = 10'd268;
  localparam logic [FreqW-1:0] FreqReset    = 10'd30;
  localparam logic [StepW-1:0] StepReset    = 7'd1;
  localparam logic [StepW-1:0] StepMax      = 7'd100;
  localparam logic [StepW-1:0] StepMin      = 7'd1;

  localparam logic [WordW-1:0] WordReset  = 16'h2100;
  localparam logic [WordW-1:0] WordFreq   = 16'h4000;
  localparam logic [WordW-1:0] WordPhase  = 16'hC000;
  localparam logic [WordW-1:0] WordSync   = 16'h2000;
  localparam logic [CsW-1:0]   CsAll      = 3'd7;

  localparam logic [3:0] LastFrameIdx = 4'd12;

  typedef struct packed {
    logic             burst;
    logic             drive;
    logic [FreqW-1:0] freq;
    logic [StepW-1:0] step;
    logic             enabled;
  } cmd_t;

  function automatic logic [11:0] phase_word(input logic [1:0] chip);
    logic [11:0] p;
    unique case (chip)
      2'd1:    p = 12'd2731;
      2'd2:    p = 12'd1365;
      default: p = 12'd0;
    endcase
    return p;
  endfunction

endpackage

// File: rtl/ifpdl_front.sv
// ----------------------------------------------------------------------------
// ifpdl_front
// Button poll handling: frequency, step, enable and edge state; one command
// per accepted poll.
// ----------------------------------------------------------------------------
module ifpdl_front (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                accept_i,
  input  logic                                btn_up_i,
  input  logic                                btn_down_i,
  input  logic                                btn_left_i,
  input  logic                                btn_right_i,
  input  logic                                btn_ctrl_i,
  input  logic [ifpdl_pkg::FreqW-1:0]         freq_min_i,
  input  logic [ifpdl_pkg::FreqW-1:0]         freq_max_i,
  output ifpdl_pkg::cmd_t                     cmd_o
);

  logic [ifpdl_pkg::FreqW-1:0] freq_q, freq_d, freq_up;
  logic [ifpdl_pkg::StepW-1:0] step_q, step_d, step_l;
  logic                        enabled_q, enabled_d;
  logic                        programmed_q, programmed_d;
  logic                        left_q, left_d, right_q, right_d, ctrl_q, ctrl_d;
  logic [ifpdl_pkg::FreqW:0]   sum;
  logic [ifpdl_pkg::FreqW:0]   diff;
  logic [10:0]                 times10;
  logic [14:0]                 div10;
  logic                        prog;

  always_comb begin
    freq_d  = freq_q;
    step_d  = step_q;
    left_d  = left_q;
    right_d = right_q;
    freq_up = freq_q;
    step_l  = step_q;
    sum     = {1'b0, freq_q} + {4'd0, step_q};
    diff    = '0;
    times10 = '0;
    div10   = '0;
    if (!enabled_q) begin
      if (btn_up_i) begin
        freq_up = (sum < {1'b0, freq_max_i}) ? sum[ifpdl_pkg::FreqW-1:0] : freq_max_i;
      end
      freq_d = freq_up;
      if (btn_down_i) begin
        diff = {1'b0, freq_up} - {4'd0, step_q};
        freq_d = (!diff[ifpdl_pkg::FreqW] && (diff[ifpdl_pkg::FreqW-1:0] > freq_min_i)) ?
                 diff[ifpdl_pkg::FreqW-1:0] : freq_min_i;
      end
      if (btn_left_i && !left_q && (step_q < ifpdl_pkg::StepMax)) begin
        times10 = {4'd0, step_q} * 11'd10;
        step_l  = times10[ifpdl_pkg::StepW-1:0];
      end
      step_d = step_l;
      if (btn_right_i && !right_q && (step_l > ifpdl_pkg::StepMin)) begin
        div10  = {8'd0, step_l} * 15'd205;
        step_d = {3'd0, div10[14:11]};
      end
      left_d  = btn_left_i;
      right_d = btn_right_i;
    end
    enabled_d = (btn_ctrl_i && !ctrl_q) ? !enabled_q : enabled_q;
    ctrl_d    = btn_ctrl_i;
    prog      = enabled_d && !programmed_q;
    if (prog) begin
      programmed_d = 1'b1;
    end else if (!enabled_d) begin
      programmed_d = 1'b0;
    end else begin
      programmed_d = programmed_q;
    end
  end

  assign cmd_o = '{burst: prog, drive: programmed_d, freq: freq_d,
                   step: step_d, enabled: enabled_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_q       <= ifpdl_pkg::FreqReset;
      step_q       <= ifpdl_pkg::StepReset;
      enabled_q    <= 1'b0;
      programmed_q <= 1'b0;
      left_q       <= 1'b0;
      right_q      <= 1'b0;
      ctrl_q       <= 1'b0;
    end else if (accept_i) begin
      freq_q       <= freq_d;
      step_q       <= step_d;
      enabled_q    <= enabled_d;
      programmed_q <= programmed_d;
      left_q       <= left_d;
      right_q      <= right_d;
      ctrl_q       <= ctrl_d;
    end
  end

endmodule

// File: rtl/ifpdl_fifo.sv
// ----------------------------------------------------------------------------
// ifpdl_fifo
// Small command queue between poll handling and frame sequencing.
// ----------------------------------------------------------------------------
module ifpdl_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ifpdl_pkg::cmd_t data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output ifpdl_pkg::cmd_t data_o
);

  localparam int unsigned AW = $clog2(Depth);
  localparam int unsigned CW = $clog2(Depth + 1);

  ifpdl_pkg::cmd_t mem_q [Depth];
  logic [AW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == AW'(Depth - 1)) ? '0 : wr_q + AW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == AW'(Depth - 1)) ? '0 : rd_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// File: rtl/ifpdl_back.sv
// ----------------------------------------------------------------------------
// ifpdl_back
// Frame sequencer: expands each command into a status result or the
// thirteen synthesizer frames, through a registered result slot.
// ----------------------------------------------------------------------------
module ifpdl_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cmd_empty_i,
  input  ifpdl_pkg::cmd_t               cmd_i,
  output logic                          cmd_pop_o,
  input  logic [ifpdl_pkg::FreqW-1:0]   tuning_factor_i,
  input  logic                          pop_i,
  output logic                          empty_o,
  output logic                          frame_valid_o,
  output logic [ifpdl_pkg::CsW-1:0]     chip_select_o,
  output logic [ifpdl_pkg::WordW-1:0]   frame_word_o,
  output logic                          last_o,
  output logic                          drive_on_o,
  output logic [ifpdl_pkg::FreqW-1:0]   freq_now_o,
  output logic [ifpdl_pkg::StepW-1:0]   step_now_o,
  output logic                          enabled_now_o
);

  ifpdl_pkg::cmd_t              cmd_q;
  logic [ifpdl_pkg::TuneW-1:0]  tw_q;
  logic                         busy_q;
  logic [3:0]                   idx_q;
  logic                         out_valid_q;
  logic                         advance;
  logic                         f_valid, f_last, f_drive;
  logic [ifpdl_pkg::CsW-1:0]    f_cs;
  logic [ifpdl_pkg::WordW-1:0]  f_word;

  assign empty_o   = !out_valid_q;
  assign advance   = busy_q && (!out_valid_q || pop_i);
  assign cmd_pop_o = !busy_q && !cmd_empty_i;

  always_comb begin
    f_valid = 1'b1;
    f_last  = 1'b0;
    f_drive = 1'b0;
    f_cs    = ifpdl_pkg::CsW'(3'b001 << idx_q[3:2]);
    f_word  = ifpdl_pkg::WordReset;
    if (!cmd_q.burst) begin
      f_valid = 1'b0;
      f_last  = 1'b1;
      f_drive = cmd_q.drive;
      f_cs    = '0;
      f_word  = '0;
    end else if (idx_q == ifpdl_pkg::LastFrameIdx) begin
      f_last  = 1'b1;
      f_drive = 1'b1;
      f_cs    = ifpdl_pkg::CsAll;
      f_word  = ifpdl_pkg::WordSync;
    end else begin
      unique case (idx_q[1:0])
        2'd0: f_word = ifpdl_pkg::WordReset;
        2'd1: f_word = ifpdl_pkg::WordFreq | {2'b00, tw_q[13:0]};
        2'd2: f_word = ifpdl_pkg::WordFreq | {10'd0, tw_q[19:14]};
        2'd3: f_word = ifpdl_pkg::WordPhase | {4'd0, ifpdl_pkg::phase_word(idx_q[3:2])};
        default: f_word = ifpdl_pkg::WordReset;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      cmd_q <= cmd_i;
      tw_q  <= ifpdl_pkg::TuneW'(cmd_i.freq) * ifpdl_pkg::TuneW'(tuning_factor_i);
    end
    if (advance) begin
      frame_valid_o <= f_valid;
      chip_select_o <= f_cs;
      frame_word_o  <= f_word;
      last_o        <= f_last;
      drive_on_o    <= f_drive;
      freq_now_o    <= cmd_q.freq;
      step_now_o    <= cmd_q.step;
      enabled_now_o <= cmd_q.enabled;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_pop_o) begin
        busy_q <= 1'b1;
        idx_q  <= '0;
      end else if (advance) begin
        busy_q <= !f_last;
        idx_q  <= idx_q + 4'd1;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/inverter_frequency_panel_dds_loader.sv
// ----------------------------------------------------------------------------
// inverter_frequency_panel_dds_loader
// Button panel for an inverter with three-synthesizer programming bursts.
// ----------------------------------------------------------------------------
// Each poll is taken and queued as a command; the frame sequencer then emits
// one result per cycle while its result slot is empty or popped: one status
// result for a plain poll, or thirteen frames when enable rises, each command
// first taking a load step. The sequencer loads a new command only once the
// last one is done. Polls are taken while the command queue has room
// (QueueDepth entries), so the front side keeps running during a burst.
// Configuration writes are always ready and should be made while idle.
module inverter_frequency_panel_dds_loader #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  push,
  output logic                                  full,
  input  logic                                  btn_up_i,
  input  logic                                  btn_down_i,
  input  logic                                  btn_left_i,
  input  logic                                  btn_right_i,
  input  logic                                  btn_ctrl_i,
  input  logic                                  pop,
  output logic                                  empty,
  output logic                                  frame_valid_o,
  output logic [ifpdl_pkg::CsW-1:0]             chip_select_o,
  output logic [ifpdl_pkg::WordW-1:0]           frame_word_o,
  output logic                                  last_o,
  output logic                                  drive_on_o,
  output logic [ifpdl_pkg::FreqW-1:0]           freq_now_o,
  output logic [ifpdl_pkg::StepW-1:0]           step_now_o,
  output logic                                  enabled_now_o,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [ifpdl_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [ifpdl_pkg::FreqW-1:0]           cfg_data_i
);

  logic [ifpdl_pkg::FreqW-1:0] freq_min_q, freq_max_q, tuning_q;
  ifpdl_pkg::cmd_t             front_cmd, queue_cmd;
  logic                        accept, q_empty, q_pop;

  assign cfg_ready_o = 1'b1;
  assign accept      = push && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_min_q <= ifpdl_pkg::FreqMinReset;
      freq_max_q <= ifpdl_pkg::FreqMaxReset;
      tuning_q   <= ifpdl_pkg::TuningReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        ifpdl_pkg::CfgFreqMin: freq_min_q <= cfg_data_i;
        ifpdl_pkg::CfgFreqMax: freq_max_q <= cfg_data_i;
        ifpdl_pkg::CfgTuning:  tuning_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  ifpdl_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .btn_up_i    (btn_up_i),
    .btn_down_i  (btn_down_i),
    .btn_left_i  (btn_left_i),
    .btn_right_i (btn_right_i),
    .btn_ctrl_i  (btn_ctrl_i),
    .freq_min_i  (freq_min_q),
    .freq_max_i  (freq_max_q),
    .cmd_o       (front_cmd)
  );

  ifpdl_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_cmd),
    .full_o  (full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (queue_cmd)
  );

  ifpdl_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_empty_i     (q_empty),
    .cmd_i           (queue_cmd),
    .cmd_pop_o       (q_pop),
    .tuning_factor_i (tuning_q),
    .pop_i           (pop),
    .empty_o         (empty),
    .frame_valid_o   (frame_valid_o),
    .chip_select_o   (chip_select_o),
    .frame_word_o    (frame_word_o),
    .last_o          (last_o),
    .drive_on_o      (drive_on_o),
    .freq_now_o      (freq_now_o),
    .step_now_o      (step_now_o),
    .enabled_now_o   (enabled_now_o)
  );

  a_sync_drives: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && frame_valid_o && chip_select_o == ifpdl_pkg::CsAll)
      |-> (drive_on_o && last_o))
    else $error("sync frame without drive or last");

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !frame_valid_o) |-> (last_o && chip_select_o == '0))
    else $error("status result malformed");

  a_burst_frames: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && frame_valid_o && chip_select_o != ifpdl_pkg::CsAll)
      |-> (!drive_on_o && !last_o && enabled_now_o))
    else $error("burst frame with drive, last or disabled");

endmodule
